// ===== rtl/svk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svk_pkg: shared types and constants of the scalar velocity filter
// Holds the item structs, the register index codes and the fixed widths of
// the serial multiplier and divider datapaths.
// ----------------------------------------------------------------------------
package svk_pkg;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_QNOISE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RNOISE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 3'd4;

	// Serial multiplier: signed A times signed B, B consumed one digit a cycle.
	localparam int MUL_AW     = 34;
	localparam int MUL_DIG_W  = 4;
	localparam int MUL_DIGITS = 9;
	localparam int MUL_BW     = MUL_DIG_W * MUL_DIGITS;
	localparam int MUL_PW     = MUL_AW + MUL_BW;
	localparam int MUL_HI_W   = MUL_AW + MUL_DIG_W + 1;
	localparam int MUL_CNT_W  = 4;

	// Width of the gain denominator.
	localparam int DEN_W = 34;

	// One input item.
	typedef struct packed {
		logic signed [31:0] tilt_angle;
		logic               flying;
		logic [7:0]         flow_quality;
		logic [30:0]        ground_distance;
		logic signed [31:0] flow_world_rate;
	} in_item_t;

	// One result item.
	typedef struct packed {
		logic signed [31:0] velocity;
		logic [30:0]        covariance;
		logic               measured;
	} out_item_t;

endpackage
`default_nettype wire

// ===== rtl/svk_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svk_mul: digit-serial signed multiplier
// Multiplies a signed A operand by a signed B operand, taking four bits of B
// per cycle from the least significant end. The top digit carries the sign.
// ----------------------------------------------------------------------------
module svk_mul (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	input  wire logic signed [svk_pkg::MUL_AW-1:0] op_a,
	input  wire logic signed [svk_pkg::MUL_BW-1:0] op_b,
	output logic                             done,
	output logic signed [svk_pkg::MUL_PW-1:0] product
);
	import svk_pkg::*;

	logic signed [MUL_AW-1:0]    a_q;
	logic signed [MUL_HI_W-1:0]  hi_q;
	logic [MUL_BW-1:0]           lo_q;
	logic [MUL_CNT_W-1:0]        cnt_q;
	logic                        busy_q;
	logic                        done_q;

	logic                        last_digit;
	logic signed [MUL_DIG_W:0]   digit;
	logic signed [MUL_HI_W-1:0]  partial;
	logic signed [MUL_HI_W-1:0]  sum;

	// The last digit is taken as signed, the others as unsigned.
	assign last_digit = (cnt_q == MUL_CNT_W'(MUL_DIGITS - 1));
	assign digit      = $signed({last_digit & lo_q[MUL_DIG_W-1], lo_q[MUL_DIG_W-1:0]});
	assign partial    = a_q * digit;
	assign sum        = hi_q + partial;

	// Accumulate one digit and shift the running product right by a digit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_digit) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= op_a;
			hi_q <= '0;
			lo_q <= op_b;
		end else if (busy_q) begin
			hi_q <= {{MUL_DIG_W{sum[MUL_HI_W-1]}}, sum[MUL_HI_W-1:MUL_DIG_W]};
			lo_q <= {sum[MUL_DIG_W-1:0], lo_q[MUL_BW-1:MUL_DIG_W]};
		end
	end

	assign done    = done_q;
	assign product = $signed({hi_q[MUL_AW-1:0], lo_q});

endmodule
`default_nettype wire

// ===== rtl/svk_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svk_div: bit-serial gain divider
// Restoring division of num * 2^FRAC_BITS by an unsigned denominator, one
// quotient bit per cycle. The quotient saturates to the positive 31-bit limit.
// ----------------------------------------------------------------------------
module svk_div #(
	parameter int FRAC_BITS = 16
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             start,
	input  wire logic [31:0]                num,
	input  wire logic [svk_pkg::DEN_W-1:0]  den,
	output logic                            done,
	output logic [30:0]                     quotient
);
	import svk_pkg::*;

	localparam int DV_W  = 32 + FRAC_BITS;
	localparam int CNT_W = $clog2(DV_W + 1);

	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [DV_W-1:0]  quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             fits;

	// Bring down the next dividend bit and try a subtract.
	assign trial = {rem_q, quo_q[DV_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and dividend/quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= '0;
			quo_q <= {num, {FRAC_BITS{1'b0}}};
		end else if (busy_q) begin
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[DV_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = (|quo_q[DV_W-1:31]) ? 31'h7FFF_FFFF : quo_q[30:0];

endmodule
`default_nettype wire

// ===== rtl/scalar_velocity_kalman.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scalar_velocity_kalman: one-axis velocity Kalman filter from optical flow
// Each item runs one predict and update step; each item gives one result.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on item/item_valid and are taken when item_stall is low. One
// item is worked on at a time; item_stall stays high until its result has
// been written into the output register. Results leave on result and
// result_valid; the receiver holds them with result_stall, and the next
// item is already accepted while an earlier result waits there.
// Registers are written on cfg_index/cfg_data with cfg_valid and cfg_ready,
// and only between items; cfg_ready is high while no item is in work and
// none is offered.
// Arithmetic: every multiply runs on one shared four-bit-per-cycle multiplier
// and the gain division is bit serial. An item without a measurement
// update needs three multiplies, four while flying; an item with one needs
// seven or eight multiplies and the division. A zero gain denominator
// skips the division.
// Reset clears the velocity and covariance state to zero and loads the
// register defaults; no result is pending after reset.
// ----------------------------------------------------------------------------
module scalar_velocity_kalman #(
	parameter int FRAC_BITS = 16
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   item_valid,
	output logic                                  item_stall,
	input  wire svk_pkg::in_item_t                item,
	output logic                                  result_valid,
	input  wire                                   result_stall,
	output svk_pkg::out_item_t                    result,
	input  wire                                   cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [svk_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [31:0]                      cfg_data
);
	import svk_pkg::*;

	// Widths and fixed-point constants.
	localparam int SAT_W = MUL_PW - FRAC_BITS + 2;
	localparam longint HOLD_RST_L   = ((64'sd99 << FRAC_BITS) + 50) / 100;
	localparam longint QNOISE_RST_L = ((64'sd5 << FRAC_BITS) + 500) / 1000;
	localparam longint RNOISE_RST_L = ((64'sd2 << FRAC_BITS) + 5) / 10;
	localparam longint DECAY_L      = ((64'sd95 << FRAC_BITS) + 50) / 100;
	localparam logic [16:0] HOLD_RST   = 17'(HOLD_RST_L);
	localparam logic [16:0] QNOISE_RST = 17'(QNOISE_RST_L);
	localparam logic [16:0] RNOISE_RST = 17'(RNOISE_RST_L);
	localparam logic signed [MUL_BW-1:0] DECAY_FX = MUL_BW'(DECAY_L);
	localparam logic signed [32:0] ONE_FX = 33'sd1 <<< FRAC_BITS;
	localparam logic signed [SAT_W-1:0] S_MAX = SAT_W'(33'sh0_7FFF_FFFF);
	localparam logic signed [SAT_W-1:0] S_MIN = ~S_MAX;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_AV,
		ST_BT,
		ST_AP,
		ST_NUM,
		ST_DEN,
		ST_DIV,
		ST_MEAS,
		ST_CORR,
		ST_COV,
		ST_DEC,
		ST_OUT
	} state_t;

	// Saturate to the signed 32-bit range.
	function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] x);
		if (x > S_MAX) begin
			return 32'sh7FFF_FFFF;
		end else if (x < S_MIN) begin
			return 32'sh8000_0000;
		end else begin
			return x[31:0];
		end
	endfunction

	// Saturate to the covariance range 0 .. 2^31-1.
	function automatic logic [30:0] sat_cov(input logic signed [SAT_W-1:0] x);
		if (x < 0) begin
			return '0;
		end else if (x > S_MAX) begin
			return 31'h7FFF_FFFF;
		end else begin
			return x[30:0];
		end
	endfunction

	// Sign-extend a 32-bit value to the working width.
	function automatic logic signed [SAT_W-1:0] widen(input logic signed [31:0] x);
		return SAT_W'(x);
	endfunction

	// Configuration registers.
	logic [16:0]        hold_q;
	logic signed [31:0] gain_q;
	logic [16:0]        qnoise_q;
	logic [16:0]        rnoise_q;
	logic [7:0]         thresh_q;

	// Filter state.
	logic signed [31:0] vel_q;
	logic [30:0]        cov_q;

	// Captured item.
	logic signed [31:0] tilt_q;
	logic               fly_q;
	logic [30:0]        dist_q;
	logic signed [31:0] rate_q;
	logic               measured_q;

	// Intermediate values.
	logic signed [31:0] vp_q;
	logic [30:0]        pp_q;
	logic [31:0]        num_q;
	logic [DEN_W-1:0]   den_q;
	logic [30:0]        k_q;
	logic signed [31:0] meas_q;
	logic signed [31:0] vel_new_q;
	logic [30:0]        cov_new_q;

	// Sequencer.
	state_t             state_q;
	logic               wait_q;
	out_item_t          result_q;
	logic               result_valid_q;

	// Arithmetic unit connections.
	logic                      mul_start;
	logic signed [MUL_AW-1:0]  mul_a;
	logic signed [MUL_BW-1:0]  mul_b;
	logic                      mul_done;
	logic signed [MUL_PW-1:0]  mul_prod;
	logic                      div_start;
	logic                      div_done;
	logic [30:0]               div_quo;

	logic signed [SAT_W-1:0]   fs_w;
	logic signed [32:0]        innov;
	logic signed [32:0]        one_minus_k;
	logic                      is_mul_state;

	svk_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.op_a    (mul_a),
		.op_b    (mul_b),
		.done    (mul_done),
		.product (mul_prod)
	);

	svk_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.num      (num_q),
		.den      (den_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Product shifted right by the fraction bits; the arithmetic shift floors.
	assign fs_w        = SAT_W'($signed(mul_prod[MUL_PW-1:FRAC_BITS]));
	assign innov       = $signed({meas_q[31], meas_q}) - $signed({vp_q[31], vp_q});
	assign one_minus_k = ONE_FX - $signed({2'b00, k_q});

	// Operand selection for the shared multiplier.
	always_comb begin
		is_mul_state = 1'b1;
		mul_a        = '0;
		mul_b        = '0;
		case (state_q)
			ST_AV: begin
				mul_a = MUL_AW'(vel_q);
				mul_b = $signed({{(MUL_BW-17){1'b0}}, hold_q});
			end
			ST_BT: begin
				mul_a = MUL_AW'(tilt_q);
				mul_b = MUL_BW'(gain_q);
			end
			ST_AP: begin
				mul_a = $signed({{(MUL_AW-31){1'b0}}, cov_q});
				mul_b = $signed({{(MUL_BW-17){1'b0}}, hold_q});
			end
			ST_NUM: begin
				mul_a = $signed({{(MUL_AW-31){1'b0}}, pp_q});
				mul_b = $signed({{(MUL_BW-17){1'b0}}, hold_q});
			end
			ST_DEN: begin
				mul_a = $signed({{(MUL_AW-32){1'b0}}, num_q});
				mul_b = $signed({{(MUL_BW-17){1'b0}}, hold_q});
			end
			ST_MEAS: begin
				mul_a = MUL_AW'(rate_q);
				mul_b = $signed({{(MUL_BW-31){1'b0}}, dist_q});
			end
			ST_CORR: begin
				mul_a = MUL_AW'(innov);
				mul_b = $signed({{(MUL_BW-31){1'b0}}, k_q});
			end
			ST_COV: begin
				mul_a = MUL_AW'(one_minus_k);
				mul_b = $signed({{(MUL_BW-31){1'b0}}, pp_q});
			end
			ST_DEC: begin
				mul_a = MUL_AW'(vp_q);
				mul_b = DECAY_FX;
			end
			default: begin
				is_mul_state = 1'b0;
			end
		endcase
	end

	assign mul_start = is_mul_state && !wait_q;
	assign div_start = (state_q == ST_DIV) && !wait_q && (den_q != '0);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q   <= HOLD_RST;
			gain_q   <= '0;
			qnoise_q <= QNOISE_RST;
			rnoise_q <= RNOISE_RST;
			thresh_q <= 8'd10;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_HOLD:   hold_q   <= cfg_data[16:0];
				CFG_GAIN:   gain_q   <= $signed(cfg_data);
				CFG_QNOISE: qnoise_q <= cfg_data[16:0];
				CFG_RNOISE: rnoise_q <= cfg_data[16:0];
				CFG_THRESH: thresh_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Item capture.
	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			tilt_q <= item.tilt_angle;
			fly_q  <= item.flying;
			dist_q <= item.ground_distance;
			rate_q <= item.flow_world_rate;
		end
	end

	// Sequencer, filter state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			wait_q         <= 1'b0;
			vel_q          <= '0;
			cov_q          <= '0;
			measured_q     <= 1'b0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
			vp_q           <= '0;
			pp_q           <= '0;
			num_q          <= '0;
			den_q          <= '0;
			k_q            <= '0;
			meas_q         <= '0;
			vel_new_q      <= '0;
			cov_new_q      <= '0;
		end else begin
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						measured_q <= (item.flow_quality > thresh_q);
						state_q    <= ST_AV;
					end
				end

				ST_DIV: begin
					// A zero denominator gives zero gain.
					if (den_q == '0) begin
						k_q     <= '0;
						state_q <= ST_MEAS;
					end else if (!wait_q) begin
						wait_q <= 1'b1;
					end else if (div_done) begin
						k_q     <= div_quo;
						wait_q  <= 1'b0;
						state_q <= ST_MEAS;
					end
				end

				ST_OUT: begin
					if (!result_valid_q || !result_stall) begin
						result_q.velocity   <= vel_new_q;
						result_q.covariance <= cov_new_q;
						result_q.measured   <= measured_q;
						result_valid_q      <= 1'b1;
						vel_q               <= vel_new_q;
						cov_q               <= cov_new_q;
						state_q             <= ST_IDLE;
					end
				end

				default: begin
					// Multiply steps: launch, then take the product when done.
					if (!wait_q) begin
						wait_q <= 1'b1;
					end else if (mul_done) begin
						wait_q <= 1'b0;
						case (state_q)
							ST_AV: begin
								vp_q    <= sat32(fs_w);
								state_q <= fly_q ? ST_BT : ST_AP;
							end
							ST_BT: begin
								vp_q    <= sat32(widen(vp_q) + widen(sat32(fs_w)));
								state_q <= ST_AP;
							end
							ST_AP: begin
								pp_q <= sat_cov(fs_w
									+ $signed({{(SAT_W-17){1'b0}}, qnoise_q}));
								state_q <= measured_q ? ST_NUM : ST_DEC;
							end
							ST_NUM: begin
								num_q   <= fs_w[31:0];
								state_q <= ST_DEN;
							end
							ST_DEN: begin
								den_q   <= fs_w[DEN_W-1:0]
									+ {{(DEN_W-17){1'b0}}, rnoise_q};
								state_q <= ST_DIV;
							end
							ST_MEAS: begin
								meas_q  <= sat32(fs_w);
								state_q <= ST_CORR;
							end
							ST_CORR: begin
								vel_new_q <= sat32(widen(vp_q) + fs_w);
								state_q   <= ST_COV;
							end
							ST_COV: begin
								cov_new_q <= sat_cov(fs_w);
								state_q   <= ST_OUT;
							end
							ST_DEC: begin
								vel_new_q <= sat32(fs_w);
								cov_new_q <= pp_q;
								state_q   <= ST_OUT;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
			endcase
		end
	end

	// A register write never lands on the edge that takes an item.
	assign item_stall   = (state_q != ST_IDLE);
	assign cfg_ready    = (state_q == ST_IDLE) && !item_valid;
	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
`default_nettype wire
